// File: hw/rtl/pdlz_pkg.sv
// Shared types and constants for the PalmDoc LZ decompressor.
// Used by the parser, the executor and the top level; depends on nothing else.
`timescale 1ns / 1ps

package pdlz_pkg;

	localparam int HISTORY_DEPTH_DEF = 2048;
	localparam int RECORD_LIMIT_DEF  = 4096;
	localparam int CMD_FIFO_DEPTH    = 4;
	localparam int RES_FIFO_DEPTH    = 4;

	localparam int DIST_W = 11;
	localparam int LEN_W  = 4;

	localparam logic [7:0] TOKEN_PAIR_MIN  = 8'h80;
	localparam logic [7:0] TOKEN_SPACE_MIN = 8'hC0;
	localparam logic [7:0] TOKEN_RAW_MIN   = 8'h01;
	localparam logic [7:0] TOKEN_RAW_MAX   = 8'h08;
	localparam logic [7:0] SPACE_XOR_MASK  = 8'h80;
	localparam logic [7:0] SPACE_CHAR      = 8'h20;
	localparam logic [2:0] PAIR_LEN_BIAS   = 3'd3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       record_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       error;
	} result_t;

	typedef enum logic [1:0] {
		MODE_TOKEN = 2'd0,
		MODE_PAIR  = 2'd1,
		MODE_RAW   = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		CMD_BYTE  = 2'd0,
		CMD_SPACE = 2'd1,
		CMD_COPY  = 2'd2,
		CMD_CUT   = 2'd3
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t           op;
		logic [7:0]        data;
		logic [DIST_W-1:0] distance;
		logic [LEN_W-1:0]  len;
		logic              rec_end;
		logic              cut_err;
	} cmd_t;

	typedef enum logic [2:0] {
		B_IDLE  = 3'd0,
		B_SPACE = 3'd1,
		B_BYTE  = 3'd2,
		B_CHECK = 3'd3,
		B_COPY  = 3'd4,
		B_CUT   = 3'd5
	} back_state_t;

endpackage

// File: hw/rtl/pdlz_fifo.sv
// Small synchronous queue used between the decoder parts and at the output.
// Generic over the item type; depends on nothing else.
`timescale 1ns / 1ps

module pdlz_fifo #(
	parameter type item_t = logic,
	parameter int  DEPTH  = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wdata,
	output logic  full,
	input  logic  pop,
	output item_t rdata,
	output logic  empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	item_t         mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// File: hw/rtl/pdlz_front.sv
// Token parser: tracks the compressed stream syntax and turns bytes into commands.
// Depends on pdlz_pkg.
`timescale 1ns / 1ps

module pdlz_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  pdlz_pkg::in_item_t item,
	output logic               full,
	output logic               cmd_push,
	output pdlz_pkg::cmd_t     cmd,
	input  logic               cmd_full
);

	pdlz_pkg::mode_t mode_q;
	pdlz_pkg::mode_t mode_d;
	logic [5:0]      pair_first_q;
	logic [5:0]      pair_first_d;
	logic [3:0]      raw_rem_q;
	logic [3:0]      raw_rem_d;
	logic            cmd_valid;
	logic            accept;
	logic [7:0]      b;

	assign full   = cmd_full;
	assign accept = push && !cmd_full;
	assign b      = item.in_byte;

	always_comb begin
		mode_d        = mode_q;
		pair_first_d  = pair_first_q;
		raw_rem_d     = raw_rem_q;
		cmd_valid     = 1'b0;
		cmd.op        = pdlz_pkg::CMD_BYTE;
		cmd.data      = b;
		cmd.distance  = {pair_first_q, b[7:3]};
		cmd.len       = {1'b0, b[2:0]} + {1'b0, pdlz_pkg::PAIR_LEN_BIAS};
		cmd.rec_end   = item.record_end;
		cmd.cut_err   = 1'b0;

		unique case (mode_q)
			pdlz_pkg::MODE_PAIR: begin
				cmd.op    = pdlz_pkg::CMD_COPY;
				cmd_valid = 1'b1;
				mode_d    = pdlz_pkg::MODE_TOKEN;
			end
			pdlz_pkg::MODE_RAW: begin
				cmd.op    = pdlz_pkg::CMD_BYTE;
				cmd_valid = 1'b1;
				if (raw_rem_q != '0) begin
					raw_rem_d = raw_rem_q - 1'b1;
				end
				if (raw_rem_d == '0) begin
					mode_d = pdlz_pkg::MODE_TOKEN;
				end
			end
			pdlz_pkg::MODE_TOKEN: begin
				priority if (b >= pdlz_pkg::TOKEN_SPACE_MIN) begin
					cmd.op    = pdlz_pkg::CMD_SPACE;
					cmd.data  = b ^ pdlz_pkg::SPACE_XOR_MASK;
					cmd_valid = 1'b1;
				end else if (b >= pdlz_pkg::TOKEN_PAIR_MIN) begin
					pair_first_d = b[5:0];
					mode_d       = pdlz_pkg::MODE_PAIR;
				end else if (b >= pdlz_pkg::TOKEN_RAW_MIN && b <= pdlz_pkg::TOKEN_RAW_MAX) begin
					raw_rem_d = b[3:0];
					mode_d    = pdlz_pkg::MODE_RAW;
				end else begin
					cmd.op    = pdlz_pkg::CMD_BYTE;
					cmd_valid = 1'b1;
				end
			end
			default: begin
				mode_d = pdlz_pkg::MODE_TOKEN;
			end
		endcase

		// Record end with a pair or raw run still open: flag the cut.
		if (item.record_end) begin
			if (mode_d != pdlz_pkg::MODE_TOKEN) begin
				cmd.cut_err = 1'b1;
				if (!cmd_valid) begin
					cmd.op    = pdlz_pkg::CMD_CUT;
					cmd_valid = 1'b1;
				end
			end
			mode_d    = pdlz_pkg::MODE_TOKEN;
			raw_rem_d = '0;
		end
	end

	assign cmd_push = accept && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= pdlz_pkg::MODE_TOKEN;
			pair_first_q <= '0;
			raw_rem_q    <= '0;
		end else if (accept) begin
			mode_q       <= mode_d;
			pair_first_q <= pair_first_d;
			raw_rem_q    <= raw_rem_d;
		end
	end

endmodule

// File: hw/rtl/pdlz_back.sv
// Command executor: emits decoded bytes, keeps the history memory and per-record byte count.
// Depends on pdlz_pkg.
`timescale 1ns / 1ps

module pdlz_back #(
	parameter int HISTORY_DEPTH = pdlz_pkg::HISTORY_DEPTH_DEF,
	parameter int RECORD_LIMIT  = pdlz_pkg::RECORD_LIMIT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_empty,
	input  pdlz_pkg::cmd_t    cmd,
	output logic              cmd_pop,
	input  logic              res_full,
	output logic              res_push,
	output pdlz_pkg::result_t res
);

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam int CW = $clog2(RECORD_LIMIT + 1);

	pdlz_pkg::back_state_t state_q;
	pdlz_pkg::back_state_t state_d;
	pdlz_pkg::cmd_t        cmd_q;
	logic [AW-1:0]         wp_q;
	logic [AW-1:0]         wp_d;
	logic [CW-1:0]         prod_q;
	logic [CW-1:0]         prod_d;
	logic [pdlz_pkg::LEN_W-1:0] cnt_q;
	logic [pdlz_pkg::LEN_W-1:0] cnt_d;
	logic [7:0]            last_byte_q;
	logic [7:0]            hist_q [HISTORY_DEPTH];
	logic [7:0]            rd_data_q;
	logic [AW-1:0]         rd_addr;
	logic [AW:0]           rd_sum;
	logic                  hist_we;
	logic [7:0]            wdata;
	logic                  load;
	logic                  finish;
	logic                  overflow;
	logic                  bad_dist;
	logic [7:0]            copy_byte;

	assign overflow  = (prod_q >= CW'(RECORD_LIMIT));
	assign bad_dist  = (cmd_q.distance == '0) || (CW'(cmd_q.distance) > prod_q);
	// Distance one reads the byte being written right now: take it from the bypass.
	assign copy_byte = (cmd_q.distance == pdlz_pkg::DIST_W'(1)) ? last_byte_q : rd_data_q;

	always_comb begin
		state_d  = state_q;
		wp_d     = wp_q;
		prod_d   = prod_q;
		cnt_d    = cnt_q;
		cmd_pop  = 1'b0;
		load     = 1'b0;
		finish   = 1'b0;
		hist_we  = 1'b0;
		wdata    = cmd_q.data;
		res_push = 1'b0;
		res      = '0;

		unique case (state_q)
			pdlz_pkg::B_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					load    = 1'b1;
					cnt_d   = cmd.len;
					unique case (cmd.op)
						pdlz_pkg::CMD_SPACE: state_d = pdlz_pkg::B_SPACE;
						pdlz_pkg::CMD_BYTE:  state_d = pdlz_pkg::B_BYTE;
						pdlz_pkg::CMD_COPY:  state_d = pdlz_pkg::B_CHECK;
						pdlz_pkg::CMD_CUT:   state_d = pdlz_pkg::B_CUT;
						default:             state_d = pdlz_pkg::B_IDLE;
					endcase
				end
			end
			pdlz_pkg::B_SPACE: begin
				if (!res_full) begin
					res_push = 1'b1;
					if (overflow) begin
						res.error    = 1'b1;
						res.run_last = 1'b1;
						finish       = 1'b1;
					end else begin
						wdata        = pdlz_pkg::SPACE_CHAR;
						res.out_byte = pdlz_pkg::SPACE_CHAR;
						hist_we      = 1'b1;
						state_d      = pdlz_pkg::B_BYTE;
					end
				end
			end
			pdlz_pkg::B_BYTE: begin
				if (!res_full) begin
					res_push = 1'b1;
					if (overflow) begin
						res.error    = 1'b1;
						res.run_last = 1'b1;
						finish       = 1'b1;
					end else begin
						res.out_byte = cmd_q.data;
						res.run_last = !cmd_q.cut_err;
						hist_we      = 1'b1;
						if (cmd_q.cut_err) begin
							state_d = pdlz_pkg::B_CUT;
						end else begin
							finish = 1'b1;
						end
					end
				end
			end
			pdlz_pkg::B_CHECK: begin
				// The first history read goes out this cycle.
				if (bad_dist) begin
					if (!res_full) begin
						res_push     = 1'b1;
						res.error    = 1'b1;
						res.run_last = 1'b1;
						finish       = 1'b1;
					end
				end else begin
					state_d = pdlz_pkg::B_COPY;
				end
			end
			pdlz_pkg::B_COPY: begin
				if (!res_full) begin
					res_push = 1'b1;
					if (overflow) begin
						res.error    = 1'b1;
						res.run_last = 1'b1;
						finish       = 1'b1;
					end else begin
						wdata        = copy_byte;
						res.out_byte = copy_byte;
						res.run_last = (cnt_q == pdlz_pkg::LEN_W'(1)) && !cmd_q.cut_err;
						hist_we      = 1'b1;
						cnt_d        = cnt_q - 1'b1;
						if (cnt_q == pdlz_pkg::LEN_W'(1)) begin
							if (cmd_q.cut_err) begin
								state_d = pdlz_pkg::B_CUT;
							end else begin
								finish = 1'b1;
							end
						end
					end
				end
			end
			pdlz_pkg::B_CUT: begin
				if (!res_full) begin
					res_push     = 1'b1;
					res.error    = 1'b1;
					res.run_last = 1'b1;
					finish       = 1'b1;
				end
			end
			default: begin
				state_d = pdlz_pkg::B_IDLE;
			end
		endcase

		if (hist_we) begin
			wp_d   = (wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			prod_d = prod_q + 1'b1;
		end

		if (finish) begin
			state_d = pdlz_pkg::B_IDLE;
			if (cmd_q.rec_end) begin
				prod_d = '0;
			end
		end

		// Source of the next copy byte: next write position minus the distance.
		rd_sum = {1'b0, wp_d} + (AW+1)'(HISTORY_DEPTH) - (AW+1)'(cmd_q.distance);
		if (rd_sum >= (AW+1)'(HISTORY_DEPTH)) begin
			rd_sum = rd_sum - (AW+1)'(HISTORY_DEPTH);
		end
		rd_addr = rd_sum[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pdlz_pkg::B_IDLE;
			wp_q    <= '0;
			prod_q  <= '0;
		end else begin
			state_q <= state_d;
			wp_q    <= wp_d;
			prod_q  <= prod_d;
		end
	end

	always_ff @(posedge clk) begin
		cnt_q <= cnt_d;
		if (load) begin
			cmd_q <= cmd;
		end
		if (hist_we) begin
			last_byte_q <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_q[wp_q] <= wdata;
		end
		rd_data_q <= hist_q[rd_addr];
	end

endmodule

// File: hw/rtl/palmdoc_lz_decompressor.sv
// Top level of the PalmDoc LZ77 record decompressor.
// Depends on pdlz_pkg, pdlz_front, pdlz_fifo and pdlz_back.
`timescale 1ns / 1ps

// Usage
// Input channel: drive item (one compressed byte plus record_end) and raise push;
// the transfer happens on a clock edge with push high and full low.
// Result channel: while empty is low, result holds the oldest decoded byte
// (run_last marks the last result of its input byte, error marks an error
// result with out_byte zero); raise pop to take it, the transfer happens on
// an edge with pop high and empty low.
// Path: a literal byte passes the command queue, executor and result queue.
// Throughput: the executor emits one result per cycle while the result queue is
// not full, taking one command at a time and fetching it in its IDLE state; a
// literal then takes BYTE, a space pair SPACE and BYTE, a copy pair (two input
// bytes) CHECK and one COPY step per output byte, a pair opener alone nothing.
// The rate is set by the executor sequencer and its single history write port.
// Stalls: if pop stays low the result queue fills, the executor holds, then
// the command queue fills and full rises; nothing is lost.
// Reset (arst_n low): clears parse state, queues, write pointer and record byte
// count. History contents are not reset; a copy may reach back only into bytes
// of the current record, and no clearing pass runs.

module palmdoc_lz_decompressor #(
	parameter int HISTORY_DEPTH = pdlz_pkg::HISTORY_DEPTH_DEF,
	parameter int RECORD_LIMIT  = pdlz_pkg::RECORD_LIMIT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  pdlz_pkg::in_item_t item,
	output logic               full,
	input  logic               pop,
	output pdlz_pkg::result_t  result,
	output logic               empty
);

	logic              cmd_push;
	logic              cmd_full;
	logic              cmd_pop;
	logic              cmd_empty;
	pdlz_pkg::cmd_t    cmd_in;
	pdlz_pkg::cmd_t    cmd_out;
	logic              res_push;
	logic              res_full;
	pdlz_pkg::result_t res_in;

	// Parse tokens and queue one command per byte that produces output.
	pdlz_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.cmd_push (cmd_push),
		.cmd      (cmd_in),
		.cmd_full (cmd_full)
	);

	// Decouple parser from executor so each can stall on its own.
	pdlz_fifo #(
		.item_t (pdlz_pkg::cmd_t),
		.DEPTH  (pdlz_pkg::CMD_FIFO_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	// Execute commands: literals, space pairs, history copies and errors.
	pdlz_back #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.RECORD_LIMIT  (RECORD_LIMIT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	// Hold finished results until the receiver takes them.
	pdlz_fifo #(
		.item_t (pdlz_pkg::result_t),
		.DEPTH  (pdlz_pkg::RES_FIFO_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule
